### hdl/crc24q_frame_engine_defines.svh
// Assertion macros used by the CRC-24Q frame engine checker.
`ifndef CRC24Q_FRAME_ENGINE_DEFINES_SVH
`define CRC24Q_FRAME_ENGINE_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define CRC24Q_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst_n is low.
`define CRC24Q_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/crc24q_pkg.sv
// Shared types, constants and the byte-wide CRC-24Q update.
`timescale 1ns / 1ps
`default_nettype none
package crc24q_pkg;

  // Generator with its x^24 term, MSB-first register
  localparam logic [24:0] CRC_POLY = 25'h1864CFB;

  // Mode register codes; the spare code behaves as hash
  localparam logic [1:0] MODE_HASH  = 2'd0;
  localparam logic [1:0] MODE_SIGN  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  typedef enum logic [1:0] {
    KIND_HASH,
    KIND_SIGN,
    KIND_CHECK
  } kind_t;

  // One frame-end result handed from the fold stage to the output stage
  typedef struct packed {
    kind_t       kind;
    logic        pass;
    logic [23:0] crc;
  } frame_res_t;

  // Fold one byte into the CRC, eight shift-and-reduce steps
  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage
`default_nettype wire

### hdl/crc24q_fold.sv
// Running CRC state and the frame-end result for each accepted word.
`timescale 1ns / 1ps
`default_nettype none
module crc24q_fold (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [1:0]            mode,
  input  wire logic                  acc,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last,
  output crc24q_pkg::frame_res_t     res
);

  // full: CRC of every byte so far; lag: CRC of all but the newest two
  logic [23:0] full_crc_r, full_crc_nxt;
  logic [23:0] lag_crc_r, lag_crc_nxt;
  logic [7:0]  older_r, older_nxt;
  logic [7:0]  newer_r, newer_nxt;
  logic [1:0]  held_r, held_nxt;   // saturates at two
  logic [23:0] full_upd;
  logic [23:0] lag_upd;

  assign full_upd = crc24q_pkg::crc_byte(full_crc_r, data_byte);
  assign lag_upd  = crc24q_pkg::crc_byte(lag_crc_r, older_r);

  always_comb begin
    full_crc_nxt = full_crc_r;
    lag_crc_nxt  = lag_crc_r;
    older_nxt    = older_r;
    newer_nxt    = newer_r;
    held_nxt     = held_r;
    if (acc) begin
      if (last) begin
        full_crc_nxt = '0;
        lag_crc_nxt  = '0;
        older_nxt    = '0;
        newer_nxt    = '0;
        held_nxt     = '0;
      end else begin
        full_crc_nxt = full_upd;
        older_nxt    = newer_r;
        newer_nxt    = data_byte;
        if (held_r == 2'd2) begin
          lag_crc_nxt = lag_upd;
        end else begin
          held_nxt = held_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    res.kind = crc24q_pkg::KIND_HASH;
    res.pass = 1'b0;
    res.crc  = full_upd;
    case (mode)
      crc24q_pkg::MODE_SIGN: begin
        res.kind = crc24q_pkg::KIND_SIGN;
      end
      crc24q_pkg::MODE_CHECK: begin
        res.kind = crc24q_pkg::KIND_CHECK;
        if (held_r == 2'd2) begin
          res.crc  = lag_crc_r;
          res.pass = (older_r == lag_crc_r[23:16]) && (newer_r == lag_crc_r[15:8]) &&
                     (data_byte == lag_crc_r[7:0]);
        end else begin
          // too short to hold a trailer
          res.crc = '0;
        end
      end
      default: begin
        res.kind = crc24q_pkg::KIND_HASH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_crc_r <= '0;
      lag_crc_r  <= '0;
      older_r    <= '0;
      newer_r    <= '0;
      held_r     <= '0;
    end else begin
      full_crc_r <= full_crc_nxt;
      lag_crc_r  <= lag_crc_nxt;
      older_r    <= older_nxt;
      newer_r    <= newer_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/crc24q_out.sv
// Result holding register and output beat sequencer.
`timescale 1ns / 1ps
`default_nettype none
module crc24q_out (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  res_load,
  input  wire crc24q_pkg::frame_res_t res,
  output logic                       room,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,
  output logic                       out_tlast
);

  logic                   pend_valid_r, pend_valid_nxt;
  crc24q_pkg::frame_res_t pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  crc24q_pkg::frame_res_t rec_r, rec_nxt;
  logic [1:0]             beat_r, beat_nxt;
  logic                   out_eor;
  logic                   out_load;
  logic                   pend_take;
  logic [7:0]             sig;

  assign out_eor   = (rec_r.kind != crc24q_pkg::KIND_SIGN) || (beat_r == 2'd2);
  assign out_load  = !out_valid_r || (out_tready && out_eor);
  assign pend_take = pend_valid_r && out_load;
  assign room      = !pend_valid_r || out_load;

  always_comb begin
    pend_valid_nxt = (pend_valid_r && !pend_take) || res_load;
    pend_nxt       = res_load ? res : pend_r;
    out_valid_nxt  = out_valid_r;
    rec_nxt        = rec_r;
    beat_nxt       = beat_r;
    if (out_load) begin
      out_valid_nxt = pend_valid_r;
      rec_nxt       = pend_r;
      beat_nxt      = '0;
    end else if (out_valid_r && out_tready) begin
      beat_nxt = beat_r + 2'd1;
    end
  end

  always_comb begin
    sig = '0;
    if (rec_r.kind == crc24q_pkg::KIND_SIGN) begin
      case (beat_r)
        2'd0:    sig = rec_r.crc[23:16];
        2'd1:    sig = rec_r.crc[15:8];
        default: sig = rec_r.crc[7:0];
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_eor;
  assign out_tdata  = {7'd0, rec_r.pass, sig, rec_r.crc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      beat_r       <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      beat_r       <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    rec_r  <= rec_nxt;
  end

endmodule
`default_nettype wire

### hdl/crc24q_frame_engine.sv
// CRC-24Q frame engine: top level.
//
// Input stream (in_*): one frame byte per word, in_tlast on the final byte.
// Each byte updates the running CRC-24Q (generator 0x1864CFB, zero seed,
// MSB first, no final xor) in the cycle it is accepted.
// Result stream (out_*): words only at frame ends. cfg_wdata selects what a
// frame end gives: hash (one word, the CRC), sign (three words carrying the
// CRC bytes high, mid, low) or check (one word, pass flag set when the last
// three bytes equal the CRC of the bytes before them). out_tlast marks the
// final result word of a frame.
// Throughput: one byte per cycle while the receiver keeps up. A sign frame
// end keeps the output busy for its three words; a one-entry holding
// register lets bytes keep flowing meanwhile, so only a run of short sign
// frames paces the input down to the pace of the sign words.
// Result path: the final byte's result is registered in the holding
// register, then in the output register, where its first word is valid.
// Stall: with out_tready low the result word holds; in_tready drops only
// once a second frame end is already waiting in the holding register.
// Reset: rst_n low clears the frame state, drops both valids, mode to hash.
`timescale 1ns / 1ps
`default_nettype none
module crc24q_frame_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_wdata,   // mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [23:0] crc_value, [31:24] sig_byte,
                                        // [32] check_pass, [39:33] zero
  output logic             out_tlast    // end_of_run
);

  logic [1:0]             mode_r, mode_nxt;
  logic                   in_acc;
  logic                   room;
  crc24q_pkg::frame_res_t res;

  // mode is sampled only at frame ends
  assign mode_nxt = cfg_wen ? cfg_wdata : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= crc24q_pkg::MODE_HASH;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // take a word whenever the holding register can absorb a frame end
  assign in_tready = room;
  assign in_acc    = in_tvalid && room;

  crc24q_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .acc       (in_acc),
    .data_byte (in_tdata),
    .last      (in_tlast),
    .res       (res)
  );

  crc24q_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (in_acc && in_tlast),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### hdl/crc24q_chk.sv
// Port-level checker for the CRC-24Q frame engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "crc24q_frame_engine_defines.svh"
module crc24q_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  logic [40:0] out_word;
  logic [23:0] crc_f;
  logic [7:0]  sig_f;
  logic        pass_f;
  logic        out_stall;
  logic        out_mid;
  logic        sig_from_crc;

  assign out_word     = {out_tlast, out_tdata};
  assign crc_f        = out_tdata[23:0];
  assign sig_f        = out_tdata[31:24];
  assign pass_f       = out_tdata[32];
  assign out_stall    = out_tvalid && !out_tready;
  assign out_mid      = out_tvalid && out_tready && !out_tlast;
  assign sig_from_crc = (sig_f == crc_f[23:16]) || (sig_f == crc_f[15:8]);

  // hold a stalled word
  `CRC24Q_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "stall not held")

  // a signature run continues at once with the same CRC
  `CRC24Q_ASSERT_NEXT(a_sig_run, out_mid, out_tvalid && (crc_f == $past(crc_f)), "run broken")

  // a pass flag only on a lone check word
  `CRC24Q_ASSERT_NOW(a_pass_word, out_tvalid && pass_f, out_tlast && (sig_f == '0), "stray pass")

  // a non-final word is a signature byte taken from the CRC
  `CRC24Q_ASSERT_NOW(a_sig_byte, out_tvalid && !out_tlast, sig_from_crc, "sig byte not from CRC")

endmodule

bind crc24q_frame_engine crc24q_chk u_chk (.*);
`default_nettype wire
